### rtl/core/mips_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_pkg
// Shared types, constants and decode codes for the mips subset core.
// ----------------------------------------------------------------------------
package mips_pkg;

    localparam int unsigned DATA_WORDS_DEF = 4096;
    localparam logic [31:0] HALT_PC        = 32'hffff_ffff;
    localparam logic [31:0] SP_RESET       = 32'h0010_0000;
    localparam logic [31:0] RA_RESET       = 32'hffff_ffff;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // special function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_NOR,
        ALU_SLT,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_LUI,
        ALU_LINK
    } alu_op_t;

    typedef enum logic [2:0] {
        NX_SEQ,
        NX_REG,
        NX_JUMP,
        NX_BEQ,
        NX_BNE
    } next_sel_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_READ,
        ST_EXEC
    } bst_t;

    // classified request handed from the front to the back
    typedef struct packed {
        alu_op_t     alu_op;
        next_sel_t   next_sel;
        logic        use_imm;
        logic        sign_imm;
        logic        reg_wr;
        logic [4:0]  dest;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  shamt;
        logic [15:0] imm;
        logic [25:0] target;
        logic        load;
        logic        store;
        logic        bad;
    } dec_t;

    function automatic dec_t decode(input logic [31:0] inst);
        dec_t d;
        logic [5:0] op;
        logic [5:0] fn;
        op          = inst[31:26];
        fn          = inst[5:0];
        d.alu_op    = ALU_NOP;
        d.next_sel  = NX_SEQ;
        d.use_imm   = 1'b0;
        d.sign_imm  = 1'b0;
        d.reg_wr    = 1'b0;
        d.dest      = inst[20:16];
        d.rs        = inst[25:21];
        d.rt        = inst[20:16];
        d.shamt     = inst[10:6];
        d.imm       = inst[15:0];
        d.target    = inst[25:0];
        d.load      = 1'b0;
        d.store     = 1'b0;
        d.bad       = 1'b0;
        if (inst != 32'd0)
        begin
            if (op == OP_SPECIAL)
            begin
                d.dest   = inst[15:11];
                d.reg_wr = 1'b1;
                unique case (fn)
                    FN_ADD, FN_ADDU: d.alu_op = ALU_ADD;
                    FN_SUB, FN_SUBU: d.alu_op = ALU_SUB;
                    FN_AND:          d.alu_op = ALU_AND;
                    FN_OR:           d.alu_op = ALU_OR;
                    FN_NOR:          d.alu_op = ALU_NOR;
                    FN_SLT:          d.alu_op = ALU_SLT;
                    FN_SLTU:         d.alu_op = ALU_SLTU;
                    FN_SLL:          d.alu_op = ALU_SLL;
                    FN_SRL:          d.alu_op = ALU_SRL;
                    FN_JR:
                    begin
                        d.reg_wr   = 1'b0;
                        d.next_sel = NX_REG;
                    end
                    FN_JALR:
                    begin
                        d.alu_op   = ALU_LINK;
                        d.next_sel = NX_REG;
                    end
                    default:
                    begin
                        d.reg_wr = 1'b0;
                        d.bad    = 1'b1;
                    end
                endcase
            end
            else
            begin
                d.reg_wr  = 1'b1;
                d.use_imm = 1'b1;
                d.sign_imm = 1'b1;
                unique case (op)
                    OP_ADDI, OP_ADDIU: d.alu_op = ALU_ADD;
                    OP_ANDI:
                    begin
                        d.alu_op   = ALU_AND;
                        d.sign_imm = 1'b0;
                    end
                    OP_ORI:
                    begin
                        d.alu_op   = ALU_OR;
                        d.sign_imm = 1'b0;
                    end
                    OP_SLTI: d.alu_op = ALU_SLT;
                    OP_LUI:  d.alu_op = ALU_LUI;
                    OP_LW:
                    begin
                        d.alu_op = ALU_ADD;
                        d.load   = 1'b1;
                    end
                    OP_SW:
                    begin
                        d.alu_op = ALU_ADD;
                        d.reg_wr = 1'b0;
                        d.store  = 1'b1;
                    end
                    OP_BEQ:
                    begin
                        d.reg_wr   = 1'b0;
                        d.next_sel = NX_BEQ;
                    end
                    OP_BNE:
                    begin
                        d.reg_wr   = 1'b0;
                        d.next_sel = NX_BNE;
                    end
                    OP_J:
                    begin
                        d.reg_wr   = 1'b0;
                        d.next_sel = NX_JUMP;
                    end
                    OP_JAL:
                    begin
                        d.alu_op   = ALU_LINK;
                        d.dest     = 5'd31;
                        d.next_sel = NX_JUMP;
                    end
                    default:
                    begin
                        d.reg_wr = 1'b0;
                        d.bad    = 1'b1;
                    end
                endcase
            end
        end
        return d;
    endfunction

endpackage : mips_pkg
`default_nettype wire

### rtl/core/mips_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_front
// Accepts instruction words, decodes them and queues the decoded requests.
// ----------------------------------------------------------------------------
module mips_front
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  wire  [31:0]          instruction,
    output logic                 dq_valid,
    output mips_pkg::dec_t       dq_data,
    input  wire                  dq_take
);
    import mips_pkg::*;

    // two-entry queue of decoded requests
    dec_t       q_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign dq_valid = (cnt_reg != 2'd0);
    assign dq_data  = q_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = dq_take && dq_valid;

    // pointer and count update
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // decoded payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= decode(instruction);
        end
    end

endmodule : mips_front
`default_nettype wire

### rtl/core/mips_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_back
// Executes decoded requests: register file, pc, data memory and results.
// ----------------------------------------------------------------------------
module mips_back
#(
    parameter int unsigned DATA_WORDS = mips_pkg::DATA_WORDS_DEF
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  dq_valid,
    input  mips_pkg::dec_t       dq_data,
    output logic                 dq_take,
    output logic                 empty,
    input  wire                  pop,
    output logic [31:0]          executed_pc,
    output logic [31:0]          next_pc,
    output logic                 reg_write,
    output logic [4:0]           reg_index,
    output logic [31:0]          reg_value,
    output logic                 mem_write,
    output logic [11:0]          mem_word_address,
    output logic [31:0]          mem_data,
    output logic                 branch_taken,
    output logic                 halted,
    output logic                 bad_instruction
);
    import mips_pkg::*;

    localparam int unsigned AW = $clog2(DATA_WORDS);

    bst_t              st_reg, st_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [31:0]       pc_reg, pc_next;
    logic              stop_reg, stop_next;
    logic [31:0]       rf_reg [32];
    logic [31:0]       dmem [DATA_WORDS];
    dec_t              d_reg;
    logic [31:0]       a_reg, b_reg, ld_reg;
    logic              out_v_reg;

    // combinational execute signals
    logic [31:0]       ext_imm, opb, alu_res, addr, wval, nxt, pc4;
    logic              taken, wr, mw, skip;
    logic [AW-1:0]     widx_mem, rd_addr;
    logic [31:0]       rd_ext, rd_sum;
    logic              res_load;

    assign empty   = !out_v_reg;
    assign pc4     = pc_reg + 32'd4;
    assign ext_imm = d_reg.sign_imm ? {{16{d_reg.imm[15]}}, d_reg.imm} : {16'd0, d_reg.imm};
    assign opb     = d_reg.use_imm ? ext_imm : b_reg;
    assign addr    = a_reg + ext_imm;
    assign skip    = stop_reg || (pc_reg == HALT_PC);
    assign res_load = (st_reg == ST_EXEC) && (!out_v_reg || pop);

    // alu
    always_comb
    begin
        unique case (d_reg.alu_op)
            ALU_ADD:  alu_res = a_reg + opb;
            ALU_SUB:  alu_res = a_reg - opb;
            ALU_AND:  alu_res = a_reg & opb;
            ALU_OR:   alu_res = a_reg | opb;
            ALU_NOR:  alu_res = ~(a_reg | opb);
            ALU_SLT:  alu_res = {31'd0, $signed(a_reg) < $signed(opb)};
            ALU_SLTU: alu_res = {31'd0, a_reg < opb};
            ALU_SLL:  alu_res = b_reg << d_reg.shamt;
            ALU_SRL:  alu_res = b_reg >> d_reg.shamt;
            ALU_LUI:  alu_res = {d_reg.imm, 16'd0};
            ALU_LINK: alu_res = pc_reg + 32'd8;
            default:  alu_res = 32'd0;
        endcase
    end

    // next pc and effects
    always_comb
    begin
        taken = 1'b0;
        unique case (d_reg.next_sel)
            NX_REG:  nxt = a_reg;
            NX_JUMP: nxt = {pc4[31:28], d_reg.target, 2'b00};
            NX_BEQ:
            begin
                taken = (a_reg == b_reg);
                nxt   = taken ? pc4 + {ext_imm[29:0], 2'b00} : pc4;
            end
            NX_BNE:
            begin
                taken = (a_reg != b_reg);
                nxt   = taken ? pc4 + {ext_imm[29:0], 2'b00} : pc4;
            end
            default: nxt = pc4;
        endcase
        wval     = d_reg.load ? ld_reg : alu_res;
        wr       = d_reg.reg_wr && (d_reg.dest != 5'd0) && !skip && !d_reg.bad;
        mw       = d_reg.store && !skip && !d_reg.bad;
        widx_mem = addr[AW+1:2];
    end

    // load address worked out while the operands are read
    always_comb
    begin
        rd_ext  = dq_data.sign_imm ? {{16{dq_data.imm[15]}}, dq_data.imm}
                                   : {16'd0, dq_data.imm};
        rd_sum  = rf_reg[dq_data.rs] + rd_ext;
        rd_addr = rd_sum[AW+1:2];
    end

    // sequencer: clear, read operands, execute
    always_comb
    begin
        st_next   = st_reg;
        clr_next  = clr_reg;
        pc_next   = pc_reg;
        stop_next = stop_reg;
        dq_take   = 1'b0;
        unique case (st_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DATA_WORDS - 1))
                begin
                    st_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (dq_valid)
                begin
                    dq_take = 1'b1;
                    st_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (res_load)
                begin
                    st_next = ST_READ;
                    if (!skip)
                    begin
                        if (d_reg.bad)
                        begin
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            pc_next = nxt;
                        end
                    end
                end
            end
            default: st_next = ST_READ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= 32'd0;
            stop_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            clr_reg  <= clr_next;
            pc_reg   <= pc_next;
            stop_reg <= stop_next;
            if (res_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // register file with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
            rf_reg[29] <= SP_RESET;
            rf_reg[31] <= RA_RESET;
        end
        else if (res_load && wr)
        begin
            rf_reg[d_reg.dest] <= wval;
        end
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        if (dq_take)
        begin
            d_reg <= dq_data;
            a_reg <= rf_reg[dq_data.rs];
            b_reg <= rf_reg[dq_data.rt];
        end
    end

    // data memory: clearing pass, stores, load read alongside the operands
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_CLEAR)
        begin
            dmem[clr_reg] <= 32'd0;
        end
        else if (res_load && mw)
        begin
            dmem[widx_mem] <= b_reg;
        end
        if (dq_take)
        begin
            ld_reg <= dmem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            executed_pc      <= pc_reg;
            reg_write        <= wr;
            reg_index        <= wr ? d_reg.dest : 5'd0;
            reg_value        <= wr ? wval : 32'd0;
            mem_write        <= mw;
            mem_word_address <= mw ? 12'(widx_mem) : 12'd0;
            mem_data         <= mw ? b_reg : 32'd0;
            branch_taken     <= taken && !skip && !d_reg.bad;
            bad_instruction  <= d_reg.bad && !skip;
            if (skip || d_reg.bad)
            begin
                next_pc <= pc_reg;
                halted  <= 1'b1;
            end
            else
            begin
                next_pc <= nxt;
                halted  <= (nxt == HALT_PC);
            end
        end
    end

endmodule : mips_back
`default_nettype wire

### rtl/core/mips_subset_single_cycle_core.sv
`timescale 1ns / 1ps
`default_nettype none
// steps: a pushed instruction is queued, then its operands and load word are read, then it
//   executes when the result register is empty or being popped; no new request is read until
//   it has executed, since each depends on the previous instruction's pc and registers
// reset: clears pc and flags at once; the data memory then goes through a clearing pass
//   during which requests queue but none executes
// ----------------------------------------------------------------------------
// mips_subset_single_cycle_core
// Top level: decoding front, execute back and the queue between them.
// ----------------------------------------------------------------------------
module mips_subset_single_cycle_core
#(
    parameter int unsigned DATA_WORDS = mips_pkg::DATA_WORDS_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [31:0] instruction,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] executed_pc,
    output logic [31:0] next_pc,
    output logic        reg_write,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value,
    output logic        mem_write,
    output logic [11:0] mem_word_address,
    output logic [31:0] mem_data,
    output logic        branch_taken,
    output logic        halted,
    output logic        bad_instruction
);
    import mips_pkg::*;

    logic dq_valid;
    logic dq_take;
    dec_t dq_data;

    // decode front
    mips_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .instruction (instruction),
        .dq_valid    (dq_valid),
        .dq_data     (dq_data),
        .dq_take     (dq_take)
    );

    // execute back
    mips_back #(.DATA_WORDS(DATA_WORDS)) u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .dq_valid         (dq_valid),
        .dq_data          (dq_data),
        .dq_take          (dq_take),
        .empty            (empty),
        .pop              (pop),
        .executed_pc      (executed_pc),
        .next_pc          (next_pc),
        .reg_write        (reg_write),
        .reg_index        (reg_index),
        .reg_value        (reg_value),
        .mem_write        (mem_write),
        .mem_word_address (mem_word_address),
        .mem_data         (mem_data),
        .branch_taken     (branch_taken),
        .halted           (halted),
        .bad_instruction  (bad_instruction)
    );

endmodule : mips_subset_single_cycle_core
`default_nettype wire

### rtl/core/mips_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_checker
// Port-level checks on the core's result requests.
// ----------------------------------------------------------------------------
module mips_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        empty,
    input wire        pop,
    input wire [31:0] executed_pc,
    input wire [31:0] next_pc,
    input wire        reg_write,
    input wire [4:0]  reg_index,
    input wire        bad_instruction,
    input wire        halted
);
    // a bad instruction always halts in place
    a_bad_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bad_instruction) |-> (halted && next_pc == executed_pc))
        else $error("bad instruction without halt");

    // r0 is never reported as written
    a_no_r0: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reg_write) |-> (reg_index != 5'd0))
        else $error("write to r0 reported");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(executed_pc)))
        else $error("result changed while waiting");

endmodule : mips_checker

bind mips_subset_single_cycle_core mips_checker u_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop             (pop),
    .executed_pc     (executed_pc),
    .next_pc         (next_pc),
    .reg_write       (reg_write),
    .reg_index       (reg_index),
    .bad_instruction (bad_instruction),
    .halted          (halted)
);
`default_nettype wire

### tb/sv/mips_subset_single_cycle_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_single_cycle_core_test
// Pushes a stream of instruction words into the core, works out the expected
// retire record of each one from an independent instruction-level model, and
// compares every popped record field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module mips_subset_single_cycle_core_test;
    import mips_pkg::*;

    typedef struct {
        logic [31:0] executed_pc;
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [11:0] mem_word_address;
        logic [31:0] mem_data;
        logic        branch_taken;
        logic        halted;
        logic        bad_instruction;
    } retire_t;

    // architectural model and queue of expected retire records
    class core_scoreboard;
        logic [31:0] gpr[32];
        logic [31:0] pc;
        logic [31:0] dmem[4096];
        bit          stopped;
        retire_t     retire_q[$];
        int          errors;
        int          retired;
        int          stores;
        int          branches;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            gpr[29] = SP_RESET;
            gpr[31] = RA_RESET;
            pc = '0;
            foreach (dmem[i]) dmem[i] = '0;
            stopped = 0;
            errors = 0;
            retired = 0;
            stores = 0;
            branches = 0;
        endfunction

        // execute one word; state only changes when commit is set
        function retire_t execute(logic [31:0] w, bit commit);
            retire_t r;
            logic [5:0] op;
            logic [5:0] fn;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] simm;
            logic [31:0] zimm;
            logic [31:0] jt;
            logic [31:0] nxt;
            logic [4:0] dst;
            logic [31:0] val;
            bit wr;
            bit bad;
            r = '{default: '0};
            r.executed_pc = pc;
            op = w[31:26];
            fn = w[5:0];
            a = gpr[w[25:21]];
            b = gpr[w[20:16]];
            zimm = {16'h0000, w[15:0]};
            simm = {{16{w[15]}}, w[15:0]};
            jt = ((pc + 32'd4) & 32'hf000_0000) | {4'h0, w[25:0], 2'b00};
            nxt = pc + 32'd4;
            dst = '0;
            val = '0;
            wr = 0;
            bad = 0;
            if (stopped || pc == HALT_PC)
            begin
                r.next_pc = pc;
                r.halted = 1'b1;
                return r;
            end
            if (w != 32'd0)
            begin
                if (op == OP_SPECIAL)
                begin
                    wr = 1;
                    dst = w[15:11];
                    case (fn)
                        FN_ADD, FN_ADDU: val = a + b;
                        FN_SUB, FN_SUBU: val = a - b;
                        FN_AND:  val = a & b;
                        FN_OR:   val = a | b;
                        FN_NOR:  val = ~(a | b);
                        FN_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                        FN_SLTU: val = (a < b) ? 32'd1 : 32'd0;
                        FN_SLL:  val = b << w[10:6];
                        FN_SRL:  val = b >> w[10:6];
                        FN_JR:
                        begin
                            wr = 0;
                            nxt = a;
                        end
                        FN_JALR:
                        begin
                            val = pc + 32'd8;
                            nxt = a;
                        end
                        default:
                        begin
                            wr = 0;
                            bad = 1;
                        end
                    endcase
                end
                else
                begin
                    wr = 1;
                    dst = w[20:16];
                    case (op)
                        OP_ADDI, OP_ADDIU: val = a + simm;
                        OP_ANDI: val = a & zimm;
                        OP_ORI:  val = a | zimm;
                        OP_SLTI: val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                        OP_LUI:  val = {w[15:0], 16'h0000};
                        OP_LW:   val = dmem[(a + simm) >> 2 & 32'hfff];
                        OP_SW:
                        begin
                            wr = 0;
                            r.mem_write = 1'b1;
                            r.mem_word_address = 12'((a + simm) >> 2);
                            r.mem_data = b;
                        end
                        OP_BEQ, OP_BNE:
                        begin
                            wr = 0;
                            r.branch_taken = (op == OP_BEQ) ? (a == b) : (a != b);
                            if (r.branch_taken)
                                nxt = pc + 32'd4 + (simm << 2);
                        end
                        OP_J:
                        begin
                            wr = 0;
                            nxt = jt;
                        end
                        OP_JAL:
                        begin
                            dst = 5'd31;
                            val = pc + 32'd8;
                            nxt = jt;
                        end
                        default:
                        begin
                            wr = 0;
                            bad = 1;
                        end
                    endcase
                end
            end
            if (bad)
            begin
                r = '{default: '0};
                r.executed_pc = pc;
                r.next_pc = pc;
                r.halted = 1'b1;
                r.bad_instruction = 1'b1;
                if (commit)
                    stopped = 1;
                return r;
            end
            if (wr && dst != 5'd0)
            begin
                r.reg_write = 1'b1;
                r.reg_index = dst;
                r.reg_value = val;
            end
            r.next_pc = nxt;
            r.halted = (nxt == HALT_PC);
            if (commit)
            begin
                if (r.reg_write)
                    gpr[dst] = val;
                if (r.mem_write)
                    dmem[r.mem_word_address] = r.mem_data;
                pc = nxt;
            end
            return r;
        endfunction

        // accepted request: predict and queue its retire record
        function void note_fetch(logic [31:0] w);
            retire_t r;
            r = execute(w, 1);
            retire_q.push_back(r);
            if (r.mem_write)
                stores++;
            if (r.branch_taken)
                branches++;
        endfunction

        function void field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, e, a);
            end
        endfunction

        // popped record against the oldest expectation
        function void check_retire(retire_t act);
            retire_t e;
            if (retire_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual pc %h",
                         $time, act.executed_pc);
                return;
            end
            e = retire_q.pop_front();
            retired++;
            field("executed_pc", e.executed_pc, act.executed_pc);
            field("next_pc", e.next_pc, act.next_pc);
            field("reg_write", e.reg_write, act.reg_write);
            field("reg_index", e.reg_index, act.reg_index);
            field("reg_value", e.reg_value, act.reg_value);
            field("mem_write", e.mem_write, act.mem_write);
            field("mem_word_address", e.mem_word_address, act.mem_word_address);
            field("mem_data", e.mem_data, act.mem_data);
            field("branch_taken", e.branch_taken, act.branch_taken);
            field("halted", e.halted, act.halted);
            field("bad_instruction", e.bad_instruction, act.bad_instruction);
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [31:0] instruction = '0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    retire_t     act;
    bit          gaps = 1;
    core_scoreboard sb;

    mips_subset_single_cycle_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .instruction      (instruction),
        .empty            (empty),
        .pop              (pop),
        .executed_pc      (act.executed_pc),
        .next_pc          (act.next_pc),
        .reg_write        (act.reg_write),
        .reg_index        (act.reg_index),
        .reg_value        (act.reg_value),
        .mem_write        (act.mem_write),
        .mem_word_address (act.mem_word_address),
        .mem_data         (act.mem_data),
        .branch_taken     (act.branch_taken),
        .halted           (act.halted),
        .bad_instruction  (act.bad_instruction)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("** mips_subset_single_cycle_core: FAILED **");
        $finish;
    end

    function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                           logic [4:0] rd, logic [4:0] sh);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // send one request, wait for it to be taken, then idle cycle by cycle at random
    task automatic send(logic [31:0] w);
        push <= 1'b1;
        instruction <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_fetch(w);
        while (gaps && $urandom_range(0, 99) < 38)
        begin
            push <= 1'b0;
            instruction <= $urandom;
            @(posedge clk);
        end
    endtask

    // random well-formed word that neither halts nor traps
    function automatic logic [31:0] random_word();
        logic [5:0] fns[13] = '{FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_NOR,
                                FN_SLT, FN_SLTU, FN_SLL, FN_SRL, FN_JR, FN_JALR};
        logic [5:0] ops[14] = '{OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_SLTI, OP_LUI,
                                OP_LW, OP_SW, OP_LW, OP_SW, OP_BEQ, OP_BNE, OP_J, OP_JAL};
        logic [31:0] w;
        logic [4:0] rs;
        logic [15:0] imm;
        retire_t r;
        forever
        begin
            w = $urandom;
            rs = ($urandom_range(0, 1) == 0) ? 5'(29 - $urandom_range(0, 4)) : w[25:21];
            imm = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 63) << 2) : w[15:0];
            case ($urandom_range(0, 9))
                0: ;
                1: w = 32'd0;
                2, 3, 4: w = r_word(fns[$urandom_range(0, 12)], rs, w[20:16], w[15:11],
                                    w[10:6]);
                default: w = i_word(ops[$urandom_range(0, 13)], rs, w[20:16], imm);
            endcase
            r = sb.execute(w, 0);
            if (!r.halted && !r.bad_instruction)
                return w;
        end
    endfunction

    // result side: check popped records, pop at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_retire(act);
            pop <= (!gaps || $urandom_range(0, 99) >= 38);
        end
    end

    // stimulus
    initial
    begin
        int spin;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every operation but ADDU, SUB and OR, and the special cases
        send(32'd0);
        send(i_word(OP_LUI, 5'd0, 5'd1, 16'hffff));
        send(i_word(OP_ORI, 5'd1, 5'd1, 16'hffff));
        send(i_word(OP_ADDIU, 5'd0, 5'd2, 16'h7fff));
        send(i_word(OP_ADDI, 5'd2, 5'd3, 16'h8000));
        send(r_word(FN_ADD, 5'd1, 5'd1, 5'd4, 5'd0));
        send(r_word(FN_SUBU, 5'd0, 5'd1, 5'd5, 5'd0));
        send(r_word(FN_SLT, 5'd1, 5'd2, 5'd6, 5'd0));
        send(r_word(FN_SLTU, 5'd1, 5'd2, 5'd7, 5'd0));
        send(r_word(FN_SLL, 5'd0, 5'd1, 5'd8, 5'd31));
        send(r_word(FN_SRL, 5'd0, 5'd1, 5'd9, 5'd31));
        send(r_word(FN_NOR, 5'd1, 5'd2, 5'd10, 5'd0));
        send(r_word(FN_AND, 5'd1, 5'd2, 5'd11, 5'd0));
        send(i_word(OP_SLTI, 5'd1, 5'd12, 16'h8000));
        send(i_word(OP_ANDI, 5'd1, 5'd0, 16'hffff));
        send(i_word(OP_SW, 5'd29, 5'd1, 16'hfffc));
        send(i_word(OP_LW, 5'd0, 5'd13, 16'h3fff));
        send(i_word(OP_BEQ, 5'd1, 5'd1, 16'h0004));
        send(i_word(OP_BNE, 5'd1, 5'd1, 16'h8000));
        send(i_word(OP_BNE, 5'd1, 5'd2, 16'hfffe));
        send({OP_J, 26'h3ff_ffff});
        send({OP_JAL, 26'h000_0040});
        send(i_word(OP_ORI, 5'd0, 5'd14, 16'h1000));
        send(r_word(FN_JALR, 5'd14, 5'd0, 5'd14, 5'd0));
        send(r_word(FN_JR, 5'd14, 5'd0, 5'd0, 5'd0));

        // random well-formed stream with a stretch of no idling
        for (int n = 0; n < 1900; n++)
        begin
            gaps = !(n >= 700 && n < 1000);
            send(random_word());
        end

        // stop the core: unsupported word or jump to the halt address
        if ($urandom_range(0, 1) == 0)
            send(i_word(6'h0b, 5'd1, 5'd2, 16'h1234));
        else
        begin
            send(i_word(OP_ADDIU, 5'd0, 5'd15, 16'hffff));
            send(r_word(FN_JR, 5'd15, 5'd0, 5'd0, 5'd0));
        end
        repeat (4) send($urandom);
        push <= 1'b0;

        spin = 0;
        while (sb.retire_q.size() != 0 && spin < 100000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (10) @(posedge clk);
        if (sb.retire_q.size() != 0)
        begin
            sb.errors++;
            $display("%0t: results still owed: expected 0, actual %0d", $time,
                     sb.retire_q.size());
        end

        $display("run covered %0d retired instructions, %0d stores, %0d taken branches,",
                 sb.retired, sb.stores, sb.branches);
        $display("ending with the core stopped and %0d mismatches", sb.errors);
        if (sb.errors == 0)
            $display("** mips_subset_single_cycle_core: PASSED **");
        else
            $display("** mips_subset_single_cycle_core: FAILED **");
        $finish;
    end

endmodule

### files.f
rtl/core/mips_pkg.sv
rtl/core/mips_front.sv
rtl/core/mips_back.sv
rtl/core/mips_subset_single_cycle_core.sv
rtl/core/mips_checker.sv
tb/sv/mips_subset_single_cycle_core_test.sv
